### rtl/tpcr_pkg.sv
// Shared constants for the three-point circle radius block.
// No dependencies; tpcr_div and three_point_circle_radius import this package.
package tpcr_pkg;
   localparam int COORD_BITS_DEF = 24;
   localparam int RADIUS_BITS = 32;
   localparam int QUOT_BITS = RADIUS_BITS + 1;
   localparam logic [RADIUS_BITS-1:0] RADIUS_MAX = '1;
endpackage

### rtl/tpcr_mul.sv
// Pipelined shift-add multiplier: a row of cells, one multiplier bit per cell.
// Carries several independent lanes and a side-band word alongside the products.
module tpcr_mul #(
   parameter int AW = 8,
   parameter int BW = 8,
   parameter int LANES = 1,
   parameter int SIDE_W = 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [LANES-1:0][AW-1:0]         in_a,
   input  logic [LANES-1:0][BW-1:0]         in_b,
   input  logic [SIDE_W-1:0]                in_side,
   output logic                             out_valid,
   output logic [LANES-1:0][AW+BW-1:0]      out_prod,
   output logic [SIDE_W-1:0]                out_side
);
   localparam int PW = AW + BW;

   logic [BW-1:0]                 vld_ff;
   logic [LANES-1:0][AW-1:0]      a_ff   [BW];
   logic [LANES-1:0][BW-1:0]      b_ff   [BW];
   logic [LANES-1:0][PW-1:0]      acc_ff [BW];
   logic [SIDE_W-1:0]             side_ff[BW];

   for (genvar i = 0; i < BW; i++) begin : g_cell
      logic                        cur_v;
      logic [LANES-1:0][AW-1:0]    cur_a;
      logic [LANES-1:0][BW-1:0]    cur_b;
      logic [LANES-1:0][PW-1:0]    cur_acc;
      logic [SIDE_W-1:0]           cur_side;
      logic [LANES-1:0][PW-1:0]    acc_in;

      if (i == 0) begin : g_first
         assign cur_v = in_valid;
         assign cur_a = in_a;
         assign cur_b = in_b;
         assign cur_acc = '0;
         assign cur_side = in_side;
      end else begin : g_next
         assign cur_v = vld_ff[i-1];
         assign cur_a = a_ff[i-1];
         assign cur_b = b_ff[i-1];
         assign cur_acc = acc_ff[i-1];
         assign cur_side = side_ff[i-1];
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         assign acc_in[l] = cur_acc[l] + (cur_b[l][i] ? (PW'(cur_a[l]) << i) : PW'(0));
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= cur_v;
         end
      end

      always_ff @(posedge clock) begin
         a_ff[i] <= cur_a;
         b_ff[i] <= cur_b;
         acc_ff[i] <= acc_in;
         side_ff[i] <= cur_side;
      end
   end

   assign out_valid = vld_ff[BW-1];
   assign out_prod = acc_ff[BW-1];
   assign out_side = side_ff[BW-1];
endmodule

### rtl/tpcr_sqrt.sv
// Pipelined restoring integer square root: one root bit per cell.
// Carries a side-band word alongside the root.
module tpcr_sqrt #(
   parameter int SQW = 8,
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [SQW-1:0]       in_rad,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output logic [SQW/2-1:0]     out_root,
   output logic [SIDE_W-1:0]    out_side
);
   localparam int RW = SQW / 2;

   logic [RW-1:0]       vld_ff;
   logic [SQW-1:0]      rad_ff [RW];
   logic [RW+1:0]       rem_ff [RW];
   logic [RW-1:0]       root_ff[RW];
   logic [SIDE_W-1:0]   side_ff[RW];

   for (genvar i = 0; i < RW; i++) begin : g_cell
      logic                cur_v;
      logic [SQW-1:0]      cur_rad;
      logic [RW+1:0]       cur_rem;
      logic [RW-1:0]       cur_root;
      logic [SIDE_W-1:0]   cur_side;
      logic [RW+1:0]       shifted;
      logic [RW+1:0]       trial;
      logic                fits;
      logic [RW+1:0]       rem_in;
      logic [RW-1:0]       root_in;

      if (i == 0) begin : g_first
         assign cur_v = in_valid;
         assign cur_rad = in_rad;
         assign cur_rem = '0;
         assign cur_root = '0;
         assign cur_side = in_side;
      end else begin : g_next
         assign cur_v = vld_ff[i-1];
         assign cur_rad = rad_ff[i-1];
         assign cur_rem = rem_ff[i-1];
         assign cur_root = root_ff[i-1];
         assign cur_side = side_ff[i-1];
      end

      assign shifted = {cur_rem[RW-1:0], cur_rad[SQW-1:SQW-2]};
      assign trial = {cur_root, 2'b01};
      assign fits = (shifted >= trial);
      assign rem_in = fits ? shifted - trial : shifted;
      assign root_in = {cur_root[RW-2:0], fits};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= cur_v;
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[i] <= {cur_rad[SQW-3:0], 2'b00};
         rem_ff[i] <= rem_in;
         root_ff[i] <= root_in;
         side_ff[i] <= cur_side;
      end
   end

   assign out_valid = vld_ff[RW-1];
   assign out_root = root_ff[RW-1];
   assign out_side = side_ff[RW-1];
endmodule

### rtl/tpcr_div.sv
// Pipelined restoring divider: one quotient bit per cell, most significant first.
// Depends on tpcr_pkg for the quotient width.
module tpcr_div #(
   parameter int NUMW = 8,
   parameter int DENW = 8,
   parameter int SIDE_W = 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [NUMW-1:0]                  in_num,
   input  logic [DENW-1:0]                  in_den,
   input  logic [SIDE_W-1:0]                in_side,
   output logic                             out_valid,
   output logic [tpcr_pkg::QUOT_BITS-1:0]   out_quot,
   output logic [SIDE_W-1:0]                out_side
);
   import tpcr_pkg::*;

   localparam int QB = QUOT_BITS;
   localparam int XW = NUMW + DENW + QB;

   logic [QB-1:0]       vld_ff;
   logic [NUMW-1:0]     rem_ff [QB];
   logic [DENW-1:0]     den_ff [QB];
   logic [QB-1:0]       quot_ff[QB];
   logic [SIDE_W-1:0]   side_ff[QB];

   for (genvar j = 0; j < QB; j++) begin : g_cell
      logic                cur_v;
      logic [NUMW-1:0]     cur_rem;
      logic [DENW-1:0]     cur_den;
      logic [QB-1:0]       cur_quot;
      logic [SIDE_W-1:0]   cur_side;
      logic [XW-1:0]       trial;
      logic [XW-1:0]       diff;
      logic                fits;
      logic [NUMW-1:0]     rem_in;

      if (j == 0) begin : g_first
         assign cur_v = in_valid;
         assign cur_rem = in_num;
         assign cur_den = in_den;
         assign cur_quot = '0;
         assign cur_side = in_side;
      end else begin : g_next
         assign cur_v = vld_ff[j-1];
         assign cur_rem = rem_ff[j-1];
         assign cur_den = den_ff[j-1];
         assign cur_quot = quot_ff[j-1];
         assign cur_side = side_ff[j-1];
      end

      assign trial = XW'(cur_den) << (QB - 1 - j);
      assign fits = (XW'(cur_rem) >= trial);
      assign diff = XW'(cur_rem) - trial;
      assign rem_in = fits ? diff[NUMW-1:0] : cur_rem;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else begin
            vld_ff[j] <= cur_v;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[j] <= rem_in;
         den_ff[j] <= cur_den;
         quot_ff[j] <= {cur_quot[QB-2:0], fits};
         side_ff[j] <= cur_side;
      end
   end

   assign out_valid = vld_ff[QB-1];
   assign out_quot = quot_ff[QB-1];
   assign out_side = side_ff[QB-1];
endmodule

### rtl/three_point_circle_radius.sv
// Circumradius of three points: multiplier, square-root and divider cell rows.
// Depends on tpcr_pkg, tpcr_mul, tpcr_sqrt and tpcr_div.
// Throughput: one beat per cycle; busy stays low and start is taken every cycle.
// Each cell row holds one bit step, so the depth is set by the operand widths.
// Reset clears the valid bits of every stage; payload registers are not reset.
module three_point_circle_radius #(
   parameter int COORD_BITS = tpcr_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [COORD_BITS-1:0]        req_first_x,
   input  logic signed [COORD_BITS-1:0]        req_first_y,
   input  logic signed [COORD_BITS-1:0]        req_second_x,
   input  logic signed [COORD_BITS-1:0]        req_second_y,
   input  logic signed [COORD_BITS-1:0]        req_third_x,
   input  logic signed [COORD_BITS-1:0]        req_third_y,
   output logic                                rsp_valid,
   output logic [tpcr_pkg::RADIUS_BITS-1:0]    rsp_radius,
   output logic                                rsp_degenerate,
   output logic                                rsp_saturated
);
   import tpcr_pkg::*;

   localparam int MW = COORD_BITS + 1;
   localparam int PW = 2 * MW;
   localparam int SW = PW + 1;
   localparam int NPW = SW + MW;
   localparam int NW = NPW + 1;
   localparam int EW = 2 * NW;
   localparam int SQW = EW + 4;
   localparam int RW = SQW / 2;
   localparam int NUMW = RW + 1;
   localparam int DENW = SW + 2;

   // Stage 0: offsets from the first point, split into magnitude and sign.
   logic signed [MW-1:0] ax, ay, bx, by;
   logic [3:0][MW-1:0]   mag;
   logic [3:0]           neg;
   logic                 s0_vld_ff;
   logic [3:0][MW-1:0]   s0_mag_ff;
   logic [3:0]           s0_neg_ff;

   assign busy = 1'b0;
   assign ax = MW'(req_second_x) - MW'(req_first_x);
   assign ay = MW'(req_second_y) - MW'(req_first_y);
   assign bx = MW'(req_third_x) - MW'(req_first_x);
   assign by = MW'(req_third_y) - MW'(req_first_y);
   assign neg = {by[MW-1], bx[MW-1], ay[MW-1], ax[MW-1]};
   assign mag[0] = ax[MW-1] ? MW'(-ax) : MW'(ax);
   assign mag[1] = ay[MW-1] ? MW'(-ay) : MW'(ay);
   assign mag[2] = bx[MW-1] ? MW'(-bx) : MW'(bx);
   assign mag[3] = by[MW-1] ? MW'(-by) : MW'(by);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      s0_mag_ff <= mag;
      s0_neg_ff <= neg;
   end

   // Cross product and squared lengths.
   logic [5:0][MW-1:0]   mula_a, mula_b;
   logic [5:0][PW-1:0]   mula_p;
   logic                 mula_vld;
   logic [4*MW+3:0]      mula_side;
   logic [3:0][MW-1:0]   a_mag;
   logic [3:0]           a_neg;

   assign mula_a[0] = s0_mag_ff[0];
   assign mula_b[0] = s0_mag_ff[3];
   assign mula_a[1] = s0_mag_ff[1];
   assign mula_b[1] = s0_mag_ff[2];
   assign mula_a[2] = s0_mag_ff[0];
   assign mula_b[2] = s0_mag_ff[0];
   assign mula_a[3] = s0_mag_ff[1];
   assign mula_b[3] = s0_mag_ff[1];
   assign mula_a[4] = s0_mag_ff[2];
   assign mula_b[4] = s0_mag_ff[2];
   assign mula_a[5] = s0_mag_ff[3];
   assign mula_b[5] = s0_mag_ff[3];

   tpcr_mul #(.AW(MW), .BW(MW), .LANES(6), .SIDE_W(4*MW+4)) u_mul_a (
      .clock(clock), .reset(reset), .in_valid(s0_vld_ff),
      .in_a(mula_a), .in_b(mula_b), .in_side({s0_mag_ff, s0_neg_ff}),
      .out_valid(mula_vld), .out_prod(mula_p), .out_side(mula_side)
   );

   assign a_mag = mula_side[4*MW+3:4];
   assign a_neg = mula_side[3:0];

   // Stage B: signed cross product and squared lengths.
   logic signed [PW+1:0] t1, t2, cr;
   logic                 b_vld_ff;
   logic [SW-1:0]        b_crmag_ff, b_a2_ff, b_b2_ff;
   logic                 b_crzero_ff;
   logic [3:0][MW-1:0]   b_mag_ff;
   logic [3:0]           b_neg_ff;

   assign t1 = (a_neg[0] ^ a_neg[3]) ? -$signed({2'b00, mula_p[0]}) : $signed({2'b00, mula_p[0]});
   assign t2 = (a_neg[1] ^ a_neg[2]) ? -$signed({2'b00, mula_p[1]}) : $signed({2'b00, mula_p[1]});
   assign cr = t1 - t2;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= mula_vld;
      end
   end

   always_ff @(posedge clock) begin
      b_crmag_ff <= cr[PW+1] ? SW'(-cr) : SW'(cr);
      b_crzero_ff <= (cr == '0);
      b_a2_ff <= SW'(mula_p[2]) + SW'(mula_p[3]);
      b_b2_ff <= SW'(mula_p[4]) + SW'(mula_p[5]);
      b_mag_ff <= a_mag;
      b_neg_ff <= a_neg;
   end

   // Numerator products of the center.
   logic [3:0][SW-1:0]   mulc_a;
   logic [3:0][MW-1:0]   mulc_b;
   logic [3:0][NPW-1:0]  mulc_p;
   logic                 mulc_vld;
   logic [SW+4:0]        mulc_side;
   logic [3:0]           c_neg;

   assign mulc_a[0] = b_a2_ff;
   assign mulc_b[0] = b_mag_ff[3];
   assign mulc_a[1] = b_b2_ff;
   assign mulc_b[1] = b_mag_ff[1];
   assign mulc_a[2] = b_b2_ff;
   assign mulc_b[2] = b_mag_ff[0];
   assign mulc_a[3] = b_a2_ff;
   assign mulc_b[3] = b_mag_ff[2];

   tpcr_mul #(.AW(SW), .BW(MW), .LANES(4), .SIDE_W(SW+5)) u_mul_c (
      .clock(clock), .reset(reset), .in_valid(b_vld_ff),
      .in_a(mulc_a), .in_b(mulc_b), .in_side({b_neg_ff, b_crmag_ff, b_crzero_ff}),
      .out_valid(mulc_vld), .out_prod(mulc_p), .out_side(mulc_side)
   );

   assign c_neg = mulc_side[SW+4:SW+1];

   // Stage D: signed center numerators.
   logic signed [NPW+1:0] u0, u1, u2, u3, nx, ny;
   logic                  d_vld_ff;
   logic [1:0][NW-1:0]    d_n_ff;
   logic [SW:0]           d_side_ff;

   assign u0 = c_neg[3] ? -$signed({2'b00, mulc_p[0]}) : $signed({2'b00, mulc_p[0]});
   assign u1 = c_neg[1] ? -$signed({2'b00, mulc_p[1]}) : $signed({2'b00, mulc_p[1]});
   assign u2 = c_neg[0] ? -$signed({2'b00, mulc_p[2]}) : $signed({2'b00, mulc_p[2]});
   assign u3 = c_neg[2] ? -$signed({2'b00, mulc_p[3]}) : $signed({2'b00, mulc_p[3]});
   assign nx = u0 - u1;
   assign ny = u2 - u3;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= mulc_vld;
      end
   end

   always_ff @(posedge clock) begin
      d_n_ff[0] <= nx[NPW+1] ? NW'(-nx) : NW'(nx);
      d_n_ff[1] <= ny[NPW+1] ? NW'(-ny) : NW'(ny);
      d_side_ff <= mulc_side[SW:0];
   end

   // Squares of the numerators.
   logic [1:0][EW-1:0]   mule_p;
   logic                 mule_vld;
   logic [SW:0]          mule_side;
   logic                 f_vld_ff;
   logic [SQW-1:0]       f_sum_ff;
   logic [SW:0]          f_side_ff;

   tpcr_mul #(.AW(NW), .BW(NW), .LANES(2), .SIDE_W(SW+1)) u_mul_e (
      .clock(clock), .reset(reset), .in_valid(d_vld_ff),
      .in_a(d_n_ff), .in_b(d_n_ff), .in_side(d_side_ff),
      .out_valid(mule_vld), .out_prod(mule_p), .out_side(mule_side)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= mule_vld;
      end
   end

   always_ff @(posedge clock) begin
      f_sum_ff <= (SQW'(mule_p[0]) + SQW'(mule_p[1])) << 2;
      f_side_ff <= mule_side;
   end

   // Root of four times the squared numerator length.
   logic [RW-1:0]  root;
   logic           sqrt_vld;
   logic [SW:0]    sqrt_side;
   logic           g_vld_ff;
   logic [NUMW-1:0] g_num_ff;
   logic [DENW-1:0] g_den_ff;
   logic           g_zero_ff;

   tpcr_sqrt #(.SQW(SQW), .SIDE_W(SW+1)) u_sqrt (
      .clock(clock), .reset(reset), .in_valid(f_vld_ff),
      .in_rad(f_sum_ff), .in_side(f_side_ff),
      .out_valid(sqrt_vld), .out_root(root), .out_side(sqrt_side)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else begin
         g_vld_ff <= sqrt_vld;
      end
   end

   always_ff @(posedge clock) begin
      g_num_ff <= NUMW'(root) + NUMW'({sqrt_side[SW:1], 1'b0});
      g_den_ff <= {sqrt_side[SW:1], 2'b00};
      g_zero_ff <= sqrt_side[0];
   end

   // Rounded radius as a quotient, then clamp and degenerate handling.
   logic [QUOT_BITS-1:0] quot;
   logic                 div_vld;
   logic                 div_zero;
   logic                 rsp_valid_ff;
   logic [RADIUS_BITS-1:0] rsp_radius_ff;
   logic                 rsp_degenerate_ff;
   logic                 rsp_saturated_ff;

   tpcr_div #(.NUMW(NUMW), .DENW(DENW), .SIDE_W(1)) u_div (
      .clock(clock), .reset(reset), .in_valid(g_vld_ff),
      .in_num(g_num_ff), .in_den(g_den_ff), .in_side(g_zero_ff),
      .out_valid(div_vld), .out_quot(quot), .out_side(div_zero)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_vld;
      end
   end

   always_ff @(posedge clock) begin
      rsp_degenerate_ff <= div_zero;
      rsp_saturated_ff <= ~div_zero & quot[QUOT_BITS-1];
      if (div_zero) begin
         rsp_radius_ff <= '0;
      end else if (quot[QUOT_BITS-1]) begin
         rsp_radius_ff <= RADIUS_MAX;
      end else begin
         rsp_radius_ff <= quot[RADIUS_BITS-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_radius = rsp_radius_ff;
   assign rsp_degenerate = rsp_degenerate_ff;
   assign rsp_saturated = rsp_saturated_ff;

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_radius == '0)
      else $error("degenerate beat carries a nonzero radius");
   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_radius == RADIUS_MAX)
      else $error("saturated beat is not clamped");
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_degenerate && rsp_saturated))
      else $error("degenerate and saturated both set");
   a_div_to_out: assert property (@(posedge clock) disable iff (reset)
      div_vld |=> rsp_valid)
      else $error("divider beat lost before the output");
endmodule
